>>> hw/rtl/prl_pkg.sv
package prl_pkg;

   // Storage sizes and field widths.
   localparam int MAX_LINES  = 1024;
   localparam int LINE_AW    = $clog2(MAX_LINES);
   localparam int LINE_CW    = LINE_AW + 1;
   localparam int LINE_W     = 48;
   localparam int MAX_WIDTH  = 4096;
   localparam int ROW_AW     = $clog2(MAX_WIDTH);
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_THICK  = 128;
   localparam int SAMPLE_W   = 24;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int THICK_W    = 8;
   localparam int VALUE_W    = 40;
   localparam int CORR_W     = 48;
   localparam int SUM_W      = 44;
   localparam int NW_W       = 18;
   localparam int DIV_N_W    = 52;
   localparam int DIV_D_W    = 18;
   localparam int DIV_CNT_W  = $clog2(DIV_N_W);
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_LADDR,
      ST_LDATA,
      ST_MUL,
      ST_CDIV,
      ST_CWAIT,
      ST_XPOS,
      ST_WIN,
      ST_AVG,
      ST_AWAIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic line_rd;
      logic line_latch;
      logic mul_go;
      logic cdiv_go;
      logic xpos_go;
      logic win_rd;
      logic next_line;
      logic avg_go;
      logic avg_done;
      logic emit_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic row_nz;
      logic drain_pend;
      logic pass_pend;
      logic more_lines;
      logic line_active;
      logic win_empty;
      logic win_last;
      logic div_done;
      logic nw_zero;
      logic out_free;
   } stat_type;

endpackage

>>> hw/rtl/prl_ram.sv
module prl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/prl_div.sv
module prl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [prl_pkg::DIV_N_W-1:0]  dividend,
   input  logic [prl_pkg::DIV_D_W-1:0]  divisor,
   output logic                         done,
   output logic [prl_pkg::DIV_N_W-1:0]  quotient
);
   import prl_pkg::*;

   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_N_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_D_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/prl_ctrl.sv
module prl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  prl_pkg::op_type    req_op,
   input  prl_pkg::stat_type  stat,
   output logic               req_ready,
   output prl_pkg::cmd_type   cmd
);
   import prl_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_op == OP_SAMPLE && stat.row_nz) ||
                   (req_op == OP_FLUSH && stat.drain_pend)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = stat.pass_pend ? ST_LADDR : ST_IDLE;
            end
         end
         ST_LADDR: state_in = stat.more_lines ? ST_LDATA : ST_AVG;
         ST_LDATA: state_in = stat.line_active ? ST_MUL : ST_LADDR;
         ST_MUL:   state_in = ST_CDIV;
         ST_CDIV:  state_in = ST_CWAIT;
         ST_CWAIT: begin
            if (stat.div_done) begin
               state_in = ST_XPOS;
            end
         end
         ST_XPOS:  state_in = stat.win_empty ? ST_LADDR : ST_WIN;
         ST_WIN: begin
            if (stat.win_last) begin
               state_in = ST_LADDR;
            end
         end
         ST_AVG:   state_in = stat.nw_zero ? ST_IDLE : ST_AWAIT;
         ST_AWAIT: begin
            if (stat.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_EMIT:  cmd.emit_load = stat.out_free;
         ST_LADDR: cmd.line_rd = stat.more_lines;
         ST_LDATA: begin
            cmd.line_latch = stat.line_active;
            cmd.next_line  = !stat.line_active;
         end
         ST_MUL:   cmd.mul_go = 1'b1;
         ST_CDIV:  cmd.cdiv_go = 1'b1;
         ST_CWAIT: ;
         ST_XPOS: begin
            cmd.xpos_go   = 1'b1;
            cmd.next_line = stat.win_empty;
         end
         ST_WIN: begin
            cmd.win_rd    = 1'b1;
            cmd.next_line = stat.win_last;
         end
         ST_AVG:   cmd.avg_go = !stat.nw_zero;
         ST_AWAIT: cmd.avg_done = stat.div_done;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/prl_dp.sv
module prl_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  prl_pkg::cmd_type                    cmd,
   output prl_pkg::stat_type                   stat,
   input  prl_pkg::op_type                     req_op,
   input  logic [prl_pkg::COORD_W-1:0]         req_x_start,
   input  logic [prl_pkg::COORD_W-1:0]         req_y_start,
   input  logic [prl_pkg::COORD_W-1:0]         req_x_end,
   input  logic [prl_pkg::COORD_W-1:0]         req_y_end,
   input  logic signed [prl_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [prl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prl_pkg::DIM_W-1:0]           csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [prl_pkg::VALUE_W-1:0]  rsp_corrected_value,
   output logic [prl_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [prl_pkg::COORD_W-1:0]         rsp_out_col,
   output logic                                rsp_last_of_frame
);
   import prl_pkg::*;

   // Configuration and frame state.
   logic [THICK_W-1:0]        thick_ff, thick_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic [LINE_CW-1:0]        lcnt_ff, lcnt_in;
   logic [COORD_W-1:0]        row_ff, row_in;
   logic [COORD_W-1:0]        col_ff, col_in;
   logic [COORD_W-1:0]        flush_ff, flush_in;
   logic                      drain_ff, drain_in;
   logic [COORD_W-1:0]        drow_ff, drow_in;
   logic signed [CORR_W-1:0]  cum_ff, cum_in;
   // Pending emission.
   logic                      pass_ff, pass_in;
   logic [COORD_W-1:0]        crow_ff, crow_in;
   logic [COORD_W-1:0]        erow_ff, erow_in;
   logic [COORD_W-1:0]        ecol_ff, ecol_in;
   logic                      elast_ff, elast_in;
   logic                      esel_ff, esel_in;
   logic                      eclr_ff, eclr_in;
   // Row-end pass.
   logic [LINE_CW-1:0]        j_ff, j_in;
   logic [COORD_W:0]          a_ff, a_in;
   logic signed [COORD_W:0]   p_ff, p_in;
   logic [COORD_W-1:0]        q_ff, q_in;
   logic [COORD_W-1:0]        xs_ff, xs_in;
   logic signed [26:0]        prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic [COORD_W-1:0]        k_ff, k_in;
   logic [COORD_W-1:0]        hi_ff, hi_in;
   logic                      accv_ff, accv_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [NW_W-1:0]           nw_ff, nw_in;
   // Output register.
   logic                      rv_ff, rv_in;
   logic signed [VALUE_W-1:0] rval_ff, rval_in;
   logic [COORD_W-1:0]        rrow_ff, rrow_in;
   logic [COORD_W-1:0]        rcol_ff, rcol_in;
   logic                      rlast_ff, rlast_in;

   logic [DIM_W-1:0]          w_eff, h_eff;
   logic [COORD_W-1:0]        wm1, hm1;
   logic [THICK_W-1:0]        t_eff, tp, tn;
   logic                      eor, eof, flast, line_we;
   logic [COORD_W-1:0]        lxs, lys, lxe, lye;
   logic [LINE_W-1:0]         lq;
   logic [COORD_W-1:0]        qxs, qys, qxe, qye;
   logic                      rb_re, rb0_we, rb1_we;
   logic [ROW_AW-1:0]         rb_raddr;
   logic [SAMPLE_W-1:0]       rb0_q, rb1_q;
   logic signed [SAMPLE_W-1:0] cur_s, prv_s, emit_s;
   logic signed [27:0]        num;
   logic [27:0]               num_mag;
   logic signed [15:0]        qv, xq, xpos, lo, hi;
   logic [SUM_W-1:0]          sum_mag;
   logic                      div_start, div_done;
   logic [DIV_N_W-1:0]        div_n, div_q;
   logic [DIV_D_W-1:0]        div_d;
   logic signed [DIV_N_W:0]   avg;
   logic signed [DIV_N_W+1:0] tot;
   logic signed [CORR_W:0]    ev;

   // Effective register values.
   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) :
              (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == '0) ? DIM_W'(1) :
              (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
      t_eff = (thick_ff == '0) ? THICK_W'(1) :
              (thick_ff > THICK_W'(MAX_THICK)) ? THICK_W'(MAX_THICK) : thick_ff;
      wm1   = COORD_W'(w_eff - 1'b1);
      hm1   = COORD_W'(h_eff - 1'b1);
      tp    = (t_eff - 1'b1) >> 1;
      tn    = t_eff >> 1;
      eor   = ({1'b0, col_ff} + 1'b1) >= w_eff;
      eof   = ({1'b0, row_ff} + 1'b1) >= h_eff;
      flast = ({1'b0, flush_ff} + 1'b1) >= w_eff;
   end

   // Line load: order the endpoints by row and clamp them to the image.
   always_comb begin
      if (req_y_start > req_y_end) begin
         lxs = req_x_end;
         lys = req_y_end;
         lxe = req_x_start;
         lye = req_y_start;
      end else begin
         lxs = req_x_start;
         lys = req_y_start;
         lxe = req_x_end;
         lye = req_y_end;
      end
      if (lxs > wm1) lxs = wm1;
      if (lxe > wm1) lxe = wm1;
      if (lys > hm1) lys = hm1;
      if (lye > hm1) lye = hm1;
      line_we = cmd.take && req_op == OP_LOAD && lcnt_ff < LINE_CW'(MAX_LINES);
   end

   prl_ram #(.WIDTH(LINE_W), .DEPTH(MAX_LINES)) u_lines (
      .clock (clock),
      .we    (line_we),
      .waddr (lcnt_ff[LINE_AW-1:0]),
      .wdata ({lxs, lys, lxe, lye}),
      .re    (cmd.line_rd),
      .raddr (j_ff[LINE_AW-1:0]),
      .rdata (lq)
   );

   // Two row buffers, selected by row parity.
   always_comb begin
      rb_re    = cmd.take || cmd.win_rd;
      rb_raddr = cmd.win_rd ? k_ff : ((req_op == OP_FLUSH) ? flush_ff : col_ff);
      rb0_we   = cmd.take && req_op == OP_SAMPLE && !row_ff[0];
      rb1_we   = cmd.take && req_op == OP_SAMPLE && row_ff[0];
   end

   prl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row0 (
      .clock (clock),
      .we    (rb0_we),
      .waddr (col_ff),
      .wdata (req_sample),
      .re    (rb_re),
      .raddr (rb_raddr),
      .rdata (rb0_q)
   );

   prl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row1 (
      .clock (clock),
      .we    (rb1_we),
      .waddr (col_ff),
      .wdata (req_sample),
      .re    (rb_re),
      .raddr (rb_raddr),
      .rdata (rb1_q)
   );

   // Shared divider: column interpolation and window average.
   always_comb begin
      num     = {prod_ff[26], prod_ff} + $signed({16'b0, q_ff});
      num_mag = num[27] ? 28'(-num) : 28'(num);
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_start = cmd.cdiv_go || cmd.avg_go;
      if (cmd.cdiv_go) begin
         div_n = DIV_N_W'(num_mag);
         div_d = DIV_D_W'({q_ff, 1'b0});
      end else begin
         div_n = {sum_mag, 8'b0};
         div_d = nw_ff;
      end
   end

   prl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // Line fields, window bounds, emission value and average.
   always_comb begin
      qxs    = lq[47:36];
      qys    = lq[35:24];
      qxe    = lq[23:12];
      qye    = lq[11:0];
      qv     = $signed(div_q[15:0]);
      xq     = neg_ff ? -qv : qv;
      xpos   = xq + $signed({4'b0, xs_ff});
      lo     = xpos - $signed({8'b0, tp});
      if (lo < 0) lo = '0;
      hi     = xpos + $signed({8'b0, tn});
      if (hi > $signed({4'b0, wm1})) hi = $signed({4'b0, wm1});
      cur_s  = crow_ff[0] ? $signed(rb1_q) : $signed(rb0_q);
      prv_s  = crow_ff[0] ? $signed(rb0_q) : $signed(rb1_q);
      emit_s = esel_ff ? $signed(rb1_q) : $signed(rb0_q);
      ev     = $signed({{(CORR_W-SAMPLE_W-7){emit_s[SAMPLE_W-1]}}, emit_s, 8'b0})
               - $signed({cum_ff[CORR_W-1], cum_ff});
      avg    = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      tot    = $signed({{6{cum_ff[CORR_W-1]}}, cum_ff}) + $signed({avg[DIV_N_W], avg});
   end

   // Status toward the controller.
   always_comb begin
      stat.row_nz      = row_ff != '0;
      stat.drain_pend  = drain_ff;
      stat.pass_pend   = pass_ff;
      stat.more_lines  = j_ff < lcnt_ff;
      stat.line_active = qys < crow_ff && crow_ff <= qye;
      stat.win_empty   = lo > hi;
      stat.win_last    = k_ff == hi_ff;
      stat.div_done    = div_done;
      stat.nw_zero     = nw_ff == '0;
      stat.out_free    = !rv_ff || rsp_ready;
   end

   // Next state of every register.
   always_comb begin
      thick_in = thick_ff;
      width_in = width_ff;
      height_in = height_ff;
      lcnt_in  = lcnt_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      flush_in = flush_ff;
      drain_in = drain_ff;
      drow_in  = drow_ff;
      cum_in   = cum_ff;
      pass_in  = pass_ff;
      crow_in  = crow_ff;
      erow_in  = erow_ff;
      ecol_in  = ecol_ff;
      elast_in = elast_ff;
      esel_in  = esel_ff;
      eclr_in  = eclr_ff;
      j_in     = j_ff;
      a_in     = a_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      xs_in    = xs_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      hi_in    = hi_ff;
      accv_in  = cmd.win_rd;
      sum_in   = sum_ff;
      nw_in    = nw_ff;
      rv_in    = rv_ff;
      rval_in  = rval_ff;
      rrow_in  = rrow_ff;
      rcol_in  = rcol_ff;
      rlast_in = rlast_ff;

      // Configuration writes.
      if (csr_valid) begin
         case (csr_index)
            CSR_THICKNESS:    thick_in = csr_data[THICK_W-1:0];
            CSR_IMAGE_WIDTH:  width_in = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      // Request intake.
      if (cmd.take) begin
         case (req_op)
            OP_LOAD: begin
               if (line_we) lcnt_in = lcnt_ff + 1'b1;
            end
            OP_CLEAR: lcnt_in = '0;
            OP_FLUSH: begin
               erow_in  = drow_ff;
               ecol_in  = flush_ff;
               elast_in = flast;
               esel_in  = drow_ff[0];
               eclr_in  = flast;
               pass_in  = 1'b0;
               if (drain_ff) begin
                  if (flast) begin
                     drain_in = 1'b0;
                     flush_in = '0;
                  end else begin
                     flush_in = flush_ff + 1'b1;
                  end
               end
            end
            OP_SAMPLE: begin
               if (drain_ff) begin
                  drain_in = 1'b0;
                  flush_in = '0;
                  cum_in   = '0;
               end
               erow_in  = row_ff - 1'b1;
               ecol_in  = col_ff;
               elast_in = 1'b0;
               esel_in  = !row_ff[0];
               eclr_in  = 1'b0;
               crow_in  = row_ff;
               pass_in  = eor && row_ff != '0;
               j_in     = '0;
               sum_in   = '0;
               nw_in    = '0;
               if (eor) begin
                  col_in = '0;
                  if (eof) begin
                     drain_in = 1'b1;
                     drow_in  = row_ff;
                     flush_in = '0;
                     row_in   = '0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end

      // Output register.
      if (cmd.emit_load) begin
         rv_in    = 1'b1;
         rval_in  = (ev > $signed((CORR_W+1)'({1'b0, {(VALUE_W-1){1'b1}}}))) ?
                    {1'b0, {(VALUE_W-1){1'b1}}} :
                    (ev < -$signed((CORR_W+1)'({1'b1, {(VALUE_W-1){1'b0}}}))) ?
                    {1'b1, {(VALUE_W-1){1'b0}}} : ev[VALUE_W-1:0];
         rrow_in  = erow_ff;
         rcol_in  = ecol_ff;
         rlast_in = elast_ff;
         if (eclr_ff) cum_in = '0;
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end

      // Row-end pass over the active lines.
      if (cmd.line_latch) begin
         a_in  = {crow_ff - qys, 1'b1};
         p_in  = $signed({1'b0, qxe}) - $signed({1'b0, qxs});
         q_in  = qye - qys;
         xs_in = qxs;
      end
      if (cmd.mul_go) prod_in = 27'($signed({1'b0, a_ff}) * p_ff);
      if (cmd.cdiv_go) neg_in = num[27];
      if (cmd.avg_go) neg_in = sum_ff[SUM_W-1];
      if (cmd.xpos_go) begin
         k_in  = lo[COORD_W-1:0];
         hi_in = hi[COORD_W-1:0];
      end
      if (cmd.win_rd) k_in = k_ff + 1'b1;
      if (cmd.next_line) j_in = j_ff + 1'b1;
      if (accv_ff) begin
         sum_in = sum_ff + SUM_W'($signed({cur_s[SAMPLE_W-1], cur_s})
                                  - $signed({prv_s[SAMPLE_W-1], prv_s}));
         nw_in  = nw_ff + 1'b1;
      end
      if (cmd.avg_done) begin
         if (tot > $signed((DIV_N_W+2)'({1'b0, {(CORR_W-1){1'b1}}}))) begin
            cum_in = {1'b0, {(CORR_W-1){1'b1}}};
         end else if (tot < -$signed((DIV_N_W+2)'({1'b1, {(CORR_W-1){1'b0}}}))) begin
            cum_in = {1'b1, {(CORR_W-1){1'b0}}};
         end else begin
            cum_in = tot[CORR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      crow_ff  <= crow_in;
      erow_ff  <= erow_in;
      ecol_ff  <= ecol_in;
      elast_ff <= elast_in;
      esel_ff  <= esel_in;
      eclr_ff  <= eclr_in;
      a_ff     <= a_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      xs_ff    <= xs_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      hi_ff    <= hi_in;
      sum_ff   <= sum_in;
      nw_ff    <= nw_in;
      j_ff     <= j_in;
      rval_ff  <= rval_in;
      rrow_ff  <= rrow_in;
      rcol_ff  <= rcol_in;
      rlast_ff <= rlast_in;
      if (reset) begin
         thick_ff  <= THICK_W'(1);
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         lcnt_ff   <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         flush_ff  <= '0;
         drain_ff  <= 1'b0;
         drow_ff   <= '0;
         cum_ff    <= '0;
         pass_ff   <= 1'b0;
         accv_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         thick_ff  <= thick_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         lcnt_ff   <= lcnt_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         flush_ff  <= flush_in;
         drain_ff  <= drain_in;
         drow_ff   <= drow_in;
         cum_ff    <= cum_in;
         pass_ff   <= pass_in;
         accv_ff   <= accv_in;
         rv_ff     <= rv_in;
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rv_ff;
   assign rsp_corrected_value = rval_ff;
   assign rsp_out_row         = rrow_ff;
   assign rsp_out_col         = rcol_ff;
   assign rsp_last_of_frame   = rlast_ff;

endmodule

>>> hw/rtl/path_row_leveling.sv
// Channel   Handshake              Payload
// req       req_valid/req_ready    op, x_start, y_start, x_end, y_end, sample
// rsp       rsp_valid/rsp_ready    corrected_value, out_row, out_col, last_of_frame
// csr       csr_valid/csr_ready    csr_index, csr_data
//
// Loads, clears and silent requests end in ST_IDLE; an emitting sample or flush
// then waits in ST_EMIT, after the registered row-buffer read, for a free output register.
// A row-end pass reads every stored line; an active line adds a multiply, a division
// and a read per window pixel; the pass ends with the average, both on the shared divider.
// Reset clears the control state and restores the default configuration; memories need no clearing pass.
// A waiting result holds in the output register while the next request is taken.
module path_row_leveling (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic [prl_pkg::COORD_W-1:0]         req_x_start,
   input  logic [prl_pkg::COORD_W-1:0]         req_y_start,
   input  logic [prl_pkg::COORD_W-1:0]         req_x_end,
   input  logic [prl_pkg::COORD_W-1:0]         req_y_end,
   input  logic signed [prl_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [prl_pkg::VALUE_W-1:0]  rsp_corrected_value,
   output logic [prl_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [prl_pkg::COORD_W-1:0]         rsp_out_col,
   output logic                                rsp_last_of_frame,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [prl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prl_pkg::DIM_W-1:0]           csr_data
);
   import prl_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   op_type   op;

   assign op = op_type'(req_op);

   // Sequencer.
   prl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (op),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Datapath with memories, divider and output register.
   prl_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (op),
      .req_x_start         (req_x_start),
      .req_y_start         (req_y_start),
      .req_x_end           (req_x_end),
      .req_y_end           (req_y_end),
      .req_sample          (req_sample),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_corrected_value (rsp_corrected_value),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_last_of_frame   (rsp_last_of_frame)
   );

   // The divider only finishes while the block is busy with a row end.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> !req_ready)
      else $error("divider finished while requests were open");

   // A result is loaded only into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a waiting result");

   // Window reads never overlap request intake.
   a_win_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.win_rd |-> !req_ready)
      else $error("window read while requests were open");

endmodule
